[design/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, constants and the period helper for the radial pulse shader.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Fixed field widths.
    localparam int COLOR_W   = 24;
    localparam int SPEED_W   = 8;
    localparam int ELAPSED_W = 32;
    localparam int PERIOD_W  = 13;
    localparam int FRAC_W    = 16;
    localparam int DIAG_W    = 18;
    localparam int SCALE_W   = 17;
    localparam int CFG_IDX_W = 2;

    // Period after reset (speed of zero) and the Q.8 diagonal length.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 13'd5019;
    localparam logic [DIAG_W-1:0]   DIAG_Q8      = 18'd247185;

    // Distances this far from the phase give a scale of zero.
    localparam logic [15:0]        DIFF_LIMIT = 16'd13108;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 17'd65536;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED      = 2'd0,
        CFG_BASE_COLOR = 2'd1,
        CFG_ORIGIN_X   = 2'd2,
        CFG_ORIGIN_Y   = 2'd3
    } t_cfg_index;

    // Period in ms: floor(5000*(256-speed)/255), split as 19*t + floor(155*t/255).
    // The division by 255 uses a reciprocal multiply and one correction step.
    function automatic logic [PERIOD_W-1:0] period_of(input logic [SPEED_W-1:0] speed);
        logic [8:0]  t;
        logic [15:0] m;
        logic [24:0] p;
        logic [8:0]  q0;
        logic [15:0] r;
        logic [8:0]  q;
        t  = 9'd256 - {1'b0, speed};
        m  = 16'(16'd155 * {7'd0, t});
        p  = 25'({9'd0, m} * 25'd257);
        q0 = p[24:16];
        r  = m - 16'({7'd0, q0} * 16'd255);
        q  = (r >= 16'd255) ? q0 + 9'd1 : q0;
        return PERIOD_W'(13'd19 * {4'd0, t}) + {4'd0, q};
    endfunction

endpackage

[design/rps_div_cell.sv]
// ----------------------------------------------------------------------------
// rps_div_cell
// One restoring long-division step: shifts in the next dividend bit,
// subtracts the divisor when it fits and records one quotient bit.
// ----------------------------------------------------------------------------
module rps_div_cell #(
    parameter int RW = 13,
    parameter int NW = 48,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_div,
    input  logic [RW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [QW-1:0] i_quo,
    output logic [RW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [QW-1:0] o_quo
);

    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;
    logic          w_fits;
    logic [RW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [QW-1:0] r_quo;

    // Compare the shifted remainder against the divisor.
    assign w_trial = {i_rem, i_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_fits  = (w_trial >= {1'b0, i_div});

    // Step registers handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_fits ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_num <= {i_num[NW-2:0], 1'b0};
            r_quo <= {i_quo[QW-2:0], w_fits};
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

[design/rps_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rps_sqrt_cell
// One digit-by-digit square root step: takes two radicand bits and
// settles one root bit.
// ----------------------------------------------------------------------------
module rps_sqrt_cell #(
    parameter int RB = 19
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RB+1:0]   i_rem,
    input  logic [2*RB-1:0] i_num,
    input  logic [RB-1:0]   i_root,
    output logic [RB+1:0]   o_rem,
    output logic [2*RB-1:0] o_num,
    output logic [RB-1:0]   o_root
);

    logic [RB+3:0]   w_cur;
    logic [RB+3:0]   w_trial;
    logic [RB+3:0]   w_diff;
    logic            w_fits;
    logic [RB+1:0]   r_rem;
    logic [2*RB-1:0] r_num;
    logic [RB-1:0]   r_root;

    // Trial subtraction of 4*root+1 from the extended remainder.
    assign w_cur   = {i_rem, i_num[2*RB-1:2*RB-2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_fits  = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_fits ? w_diff[RB+1:0] : w_cur[RB+1:0];
            r_num  <= {i_num[2*RB-3:0], 2'b00};
            r_root <= {i_root[RB-2:0], w_fits};
        end
    end

    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_root = r_root;

endmodule

[design/radial_pulse_led_shader.sv]
// ----------------------------------------------------------------------------
// radial_pulse_led_shader
// Shades one LED per request with a ring radiating from a set origin.
//
//   Channel  Direction  Handshake                  Payload
//   in       request    i_in_valid / o_in_stall    i_elapsed_ms, i_led_x, i_led_y
//   out      result     o_out_valid / i_out_stall  o_pixel_color
//   cfg      write      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One request enters per clock unless a held result stalls the pipeline.
// The distance path is the longest: two input stages, a square
// root chain of POSITION_BITS+9 cells and a division chain of
// POSITION_BITS+25 cells, then the scale and colour stages.
// Reset clears only the valid bits and loads the registers' reset values.
// A stalled result freezes the whole pipeline, and o_in_stall follows it.
// ----------------------------------------------------------------------------
module radial_pulse_led_shader #(
    parameter int POSITION_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_elapsed_ms,
    input  logic [POSITION_BITS-1:0]      i_led_x,
    input  logic [POSITION_BITS-1:0]      i_led_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [23:0]                   o_pixel_color,
    input  logic                          i_cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rps_pkg::COLOR_W-1:0]   i_cfg_data
);

    localparam int P      = POSITION_BITS;
    localparam int R      = P + 9;
    localparam int SQ_W   = 2 * P + 1;
    localparam int QN_W   = R + rps_pkg::FRAC_W;
    localparam int MOD_NW = rps_pkg::ELAPSED_W + rps_pkg::FRAC_W;
    localparam int LT     = 2 * R + 18;
    localparam int DLY    = LT - MOD_NW;

    // Configuration registers.
    logic [rps_pkg::PERIOD_W-1:0] r_period;
    logic [rps_pkg::COLOR_W-1:0]  r_base_color;
    logic [P-1:0]                 r_origin_x;
    logic [P-1:0]                 r_origin_y;

    // Pipeline control.
    logic          w_en;
    logic [LT-1:0] r_vld;
    logic          r_sc_vld;
    logic          r_out_vld;

    // Distance front end.
    logic [P:0]      w_dx;
    logic [P:0]      w_dy;
    logic [P-1:0]    r_adx;
    logic [P-1:0]    r_ady;
    logic [SQ_W-1:0] r_sq;

    // Phase chain links.
    logic [rps_pkg::PERIOD_W-1:0] w_mrem [0:MOD_NW];
    logic [MOD_NW-1:0]            w_mnum [0:MOD_NW];
    logic [rps_pkg::FRAC_W-1:0]   w_mquo [0:MOD_NW];
    logic [rps_pkg::FRAC_W-1:0]   r_pdly [0:DLY-1];

    // Square root chain links.
    logic [R+1:0]   w_srem  [0:R];
    logic [2*R-1:0] w_snum  [0:R];
    logic [R-1:0]   w_sroot [0:R];

    // Ratio chain links.
    logic [rps_pkg::DIAG_W-1:0] w_drem [0:QN_W];
    logic [QN_W-1:0]            w_dnum [0:QN_W];
    logic [QN_W-1:0]            w_dquo [0:QN_W];

    // Scale and output stages.
    logic [QN_W-1:0]             w_phase;
    logic [QN_W-1:0]             w_ratio;
    logic [QN_W-1:0]             w_diff;
    logic [rps_pkg::SCALE_W-1:0] w_scale;
    logic [rps_pkg::SCALE_W-1:0] r_scale;
    logic [rps_pkg::COLOR_W-1:0] r_sc_color;
    logic [24:0]                 w_red;
    logic [24:0]                 w_grn;
    logic [24:0]                 w_blu;
    logic [rps_pkg::COLOR_W-1:0] r_pixel;

    // The pipeline moves unless a finished result is held.
    assign w_en        = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_vld;
    assign o_pixel_color = r_pixel;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= rps_pkg::PERIOD_RESET;
            r_base_color <= '0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rps_pkg::CFG_SPEED:
                    r_period <= rps_pkg::period_of(i_cfg_data[rps_pkg::SPEED_W-1:0]);
                rps_pkg::CFG_BASE_COLOR: r_base_color <= i_cfg_data;
                rps_pkg::CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data[P-1:0];
                rps_pkg::CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data[P-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_sc_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[LT-2:0], i_in_valid};
            r_sc_vld  <= r_vld[LT-1];
            r_out_vld <= r_sc_vld;
        end
    end

    // Absolute offsets from the origin, then the squared distance.
    assign w_dx = {1'b0, i_led_x} - {1'b0, r_origin_x};
    assign w_dy = {1'b0, i_led_y} - {1'b0, r_origin_y};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_adx <= w_dx[P] ? P'(-w_dx) : w_dx[P-1:0];
            r_ady <= w_dy[P] ? P'(-w_dy) : w_dy[P-1:0];
            r_sq  <= SQ_W'({{(P+1){1'b0}}, r_adx} * {{(P+1){1'b0}}, r_adx})
                   + SQ_W'({{(P+1){1'b0}}, r_ady} * {{(P+1){1'b0}}, r_ady});
        end
    end

    // Phase chain: elapsed mod period, then sixteen fraction bits of the phase.
    assign w_mrem[0] = '0;
    assign w_mnum[0] = {i_elapsed_ms, {rps_pkg::FRAC_W{1'b0}}};
    assign w_mquo[0] = '0;

    for (genvar k = 0; k < MOD_NW; k++) begin : g_mod
        rps_div_cell #(
            .RW(rps_pkg::PERIOD_W),
            .NW(MOD_NW),
            .QW(rps_pkg::FRAC_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (r_period),
            .i_rem (w_mrem[k]),
            .i_num (w_mnum[k]),
            .i_quo (w_mquo[k]),
            .o_rem (w_mrem[k+1]),
            .o_num (w_mnum[k+1]),
            .o_quo (w_mquo[k+1])
        );
    end

    // Hold the phase until the distance path catches up.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pdly[0] <= w_mquo[MOD_NW];
            for (int i = 1; i < DLY; i++) begin
                r_pdly[i] <= r_pdly[i-1];
            end
        end
    end

    // Square root chain: Q.8 distance.
    assign w_srem[0]  = '0;
    assign w_snum[0]  = {1'b0, r_sq, {rps_pkg::FRAC_W{1'b0}}};
    assign w_sroot[0] = '0;

    for (genvar k = 0; k < R; k++) begin : g_sqrt
        rps_sqrt_cell #(
            .RB(R)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_srem[k]),
            .i_num  (w_snum[k]),
            .i_root (w_sroot[k]),
            .o_rem  (w_srem[k+1]),
            .o_num  (w_snum[k+1]),
            .o_root (w_sroot[k+1])
        );
    end

    // Ratio chain: distance divided by the diagonal, Q.16.
    assign w_drem[0] = '0;
    assign w_dnum[0] = {w_sroot[R], {rps_pkg::FRAC_W{1'b0}}};
    assign w_dquo[0] = '0;

    for (genvar k = 0; k < QN_W; k++) begin : g_ratio
        rps_div_cell #(
            .RW(rps_pkg::DIAG_W),
            .NW(QN_W),
            .QW(QN_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_div (rps_pkg::DIAG_Q8),
            .i_rem (w_drem[k]),
            .i_num (w_dnum[k]),
            .i_quo (w_dquo[k]),
            .o_rem (w_drem[k+1]),
            .o_num (w_dnum[k+1]),
            .o_quo (w_dquo[k+1])
        );
    end

    // Scale = 1 - 5*|phase - ratio|, clamped at zero.
    assign w_phase = QN_W'(r_pdly[DLY-1]);
    assign w_ratio = w_dquo[QN_W];
    assign w_diff  = (w_phase > w_ratio) ? w_phase - w_ratio : w_ratio - w_phase;
    assign w_scale = (w_diff >= QN_W'(rps_pkg::DIFF_LIMIT)) ? '0 :
                     rps_pkg::SCALE_ONE - rps_pkg::SCALE_W'(w_diff[13:0] * 17'd5);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scale    <= w_scale;
            r_sc_color <= r_base_color;
        end
    end

    // Each colour byte times the scale, truncated.
    assign w_red = {17'd0, r_sc_color[23:16]} * {8'd0, r_scale};
    assign w_grn = {17'd0, r_sc_color[15:8]}  * {8'd0, r_scale};
    assign w_blu = {17'd0, r_sc_color[7:0]}   * {8'd0, r_scale};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pixel <= {w_red[23:16], w_grn[23:16], w_blu[23:16]};
        end
    end

    // The period stays in its legal range.
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period != '0) && (r_period <= rps_pkg::PERIOD_RESET))
        else $error("period out of range");

    // A valid scale never exceeds one.
    a_scale_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc_vld |-> (r_scale <= rps_pkg::SCALE_ONE))
        else $error("scale above one");

    // A held result freezes the valid pipeline.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> ($stable(r_vld) && $stable(r_sc_vld)))
        else $error("pipeline moved while result held");

endmodule
